// File: hw/rtl/sirc_pkg.sv
package sirc_pkg;

    localparam int LEN_W  = 16;
    localparam int CODE_W = 24;
    localparam int SHIFT_W = 20;
    localparam int CNT_W  = 5;

    localparam logic [1:0] ACT_TIMING = 2'd0;
    localparam logic [1:0] ACT_RESET  = 2'd1;

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_KEY   = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [1:0] VAR_12 = 2'd0;
    localparam logic [1:0] VAR_15 = 2'd1;
    localparam logic [1:0] VAR_20 = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_12  = 5'd12;
    localparam logic [CNT_W-1:0] COUNT_15  = 5'd15;
    localparam logic [CNT_W-1:0] COUNT_20  = 5'd20;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [2:0] REG_VARIANTS   = 3'd0;
    localparam logic [2:0] REG_UNIT       = 3'd1;
    localparam logic [2:0] REG_HDR_PULSE  = 3'd2;
    localparam logic [2:0] REG_HDR_SPACE  = 3'd3;
    localparam logic [2:0] REG_ONE_PULSE  = 3'd4;
    localparam logic [2:0] REG_ZERO_PULSE = 3'd5;
    localparam logic [2:0] REG_GAP        = 3'd6;
    localparam logic [2:0] REG_TRAILER    = 3'd7;

    localparam logic [2:0] ST_INACTIVE  = 3'd0;
    localparam logic [2:0] ST_HDR_SPACE = 3'd1;
    localparam logic [2:0] ST_BIT_PULSE = 3'd2;
    localparam logic [2:0] ST_BIT_SPACE = 3'd3;
    localparam logic [2:0] ST_FINISHED  = 3'd4;

    // d > t - m, always true when the margin exceeds the target
    function automatic logic at_least(input logic [LEN_W-1:0] d,
                                      input logic [LEN_W-1:0] t,
                                      input logic [LEN_W-1:0] m);
        logic r;
        if (m > t)
            r = 1'b1;
        else
            r = (d > (t - m));
        return r;
    endfunction

    function automatic logic near(input logic [LEN_W-1:0] d,
                                  input logic [LEN_W-1:0] t,
                                  input logic [LEN_W-1:0] m);
        logic [LEN_W:0] hi;
        hi = {1'b0, t} + {1'b0, m};
        return at_least(d, t, m) && ({1'b0, d} < hi);
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7-i] = v[i];
        return r;
    endfunction

endpackage

// File: hw/rtl/sirc_ir_pulse_decoder_core.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: length_us; tuser: action, is_pulse
// m_*      out  m_tvalid/m_tready  tdata: variant, scan_code; tuser: status
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One result word per input word, in the cycle after acceptance; one word per cycle
// sustained while m_tready is high, set by the single decode stage feeding the
// output register. s_tready drops only while a result sits in the output register
// unaccepted. cfg_ready is always high. rst_n clears the frame state, the output valid
// and loads the register defaults.
module sirc_ir_pulse_decoder_core
    import sirc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] length_us
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] is_pulse
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] variant, [25:2] scan_code, [31:26] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [2:0]       variants_reg;
    logic [LEN_W-1:0] unit_reg;
    logic [LEN_W-1:0] hdr_pulse_reg;
    logic [LEN_W-1:0] hdr_space_reg;
    logic [LEN_W-1:0] one_pulse_reg;
    logic [LEN_W-1:0] zero_pulse_reg;
    logic [LEN_W-1:0] gap_reg;
    logic [LEN_W-1:0] trailer_reg;

    logic [2:0]         state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic              out_valid_reg;
    logic [1:0]        status_reg, status_next;
    logic [1:0]        variant_reg, variant_next;
    logic [CODE_W-1:0] code_reg, code_next;

    logic [1:0]       action;
    logic             is_pulse;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] margin;
    logic [LEN_W-1:0] gap_rem;
    logic [LEN_W-1:0] tail_len;
    logic             accept;
    logic             unit_ok;
    logic             do_finish;
    logic [7:0]       dev;
    logic [7:0]       sub;
    logic [7:0]       fn;

    assign action   = s_tuser[1:0];
    assign is_pulse = s_tuser[2];
    assign len      = s_tdata;
    assign margin   = {1'b0, unit_reg[LEN_W-1:1]};
    assign gap_rem  = (len > gap_reg) ? (len - gap_reg) : '0;
    assign unit_ok  = at_least(len, unit_reg, margin);

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        status_next  = STATUS_NONE;
        variant_next = VAR_12;
        code_next    = '0;
        do_finish    = 1'b0;
        tail_len     = len;
        dev          = '0;
        sub          = '0;
        fn           = '0;

        if (variants_reg == 3'd0)
        begin
            // all frame kinds off: every word ignored
        end
        else if (action != ACT_TIMING)
        begin
            if (action == ACT_RESET)
                state_next = ST_INACTIVE;
        end
        else if (!unit_ok)
        begin
            state_next  = ST_INACTIVE;
            status_next = STATUS_ERROR;
        end
        else
        begin
            case (state_reg)
                ST_INACTIVE:
                begin
                    if (!is_pulse || !near(len, hdr_pulse_reg, margin))
                    begin
                        state_next  = ST_INACTIVE;
                        status_next = STATUS_ERROR;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = ST_HDR_SPACE;
                    end
                end
                ST_HDR_SPACE:
                begin
                    if (is_pulse || !near(len, hdr_space_reg, margin))
                    begin
                        state_next  = ST_INACTIVE;
                        status_next = STATUS_ERROR;
                    end
                    else
                        state_next = ST_BIT_PULSE;
                end
                ST_BIT_PULSE:
                begin
                    if (!is_pulse)
                    begin
                        state_next  = ST_INACTIVE;
                        status_next = STATUS_ERROR;
                    end
                    else
                    begin
                        // shift happens even if the pulse length turns out bad
                        shift_next = {shift_reg[SHIFT_W-2:0], 1'b0};
                        if (near(len, one_pulse_reg, margin))
                        begin
                            shift_next[0] = 1'b1;
                            state_next    = ST_BIT_SPACE;
                        end
                        else if (near(len, zero_pulse_reg, margin))
                            state_next = ST_BIT_SPACE;
                        else
                        begin
                            state_next  = ST_INACTIVE;
                            status_next = STATUS_ERROR;
                        end
                        if (state_next == ST_BIT_SPACE && count_reg < COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                end
                ST_BIT_SPACE:
                begin
                    if (is_pulse || !at_least(len, gap_reg, margin))
                    begin
                        state_next  = ST_INACTIVE;
                        status_next = STATUS_ERROR;
                    end
                    else if (!at_least(gap_rem, unit_reg, margin))
                        state_next = ST_BIT_PULSE;
                    else
                    begin
                        do_finish = 1'b1;
                        tail_len  = gap_rem;
                    end
                end
                ST_FINISHED:
                begin
                    do_finish = 1'b1;
                end
                default:
                begin
                    state_next  = ST_INACTIVE;
                    status_next = STATUS_ERROR;
                end
            endcase

            if (do_finish)
            begin
                state_next = ST_INACTIVE;
                if (is_pulse || !at_least(tail_len, trailer_reg, margin))
                    status_next = STATUS_ERROR;
                else if (count_reg == COUNT_12)
                begin
                    dev = rev8({shift_reg[4:0], 3'b000});
                    fn  = rev8({shift_reg[11:5], 1'b0});
                    if (variants_reg[0])
                    begin
                        status_next  = STATUS_KEY;
                        variant_next = VAR_12;
                        code_next    = {dev, 8'h00, fn};
                    end
                end
                else if (count_reg == COUNT_15)
                begin
                    dev = rev8(shift_reg[7:0]);
                    fn  = rev8({shift_reg[14:8], 1'b0});
                    if (variants_reg[1])
                    begin
                        status_next  = STATUS_KEY;
                        variant_next = VAR_15;
                        code_next    = {dev, 8'h00, fn};
                    end
                end
                else if (count_reg == COUNT_20)
                begin
                    dev = rev8({shift_reg[12:8], 3'b000});
                    sub = rev8(shift_reg[7:0]);
                    fn  = rev8({shift_reg[19:13], 1'b0});
                    if (variants_reg[2])
                    begin
                        status_next  = STATUS_KEY;
                        variant_next = VAR_20;
                        code_next    = {dev, sub, fn};
                    end
                end
                else
                    status_next = STATUS_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variants_reg   <= 3'd7;
            unit_reg       <= 16'd600;
            hdr_pulse_reg  <= 16'd2400;
            hdr_space_reg  <= 16'd600;
            one_pulse_reg  <= 16'd1200;
            zero_pulse_reg <= 16'd600;
            gap_reg        <= 16'd600;
            trailer_reg    <= 16'd6000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VARIANTS:   variants_reg   <= cfg_data[2:0];
                REG_UNIT:       unit_reg       <= cfg_data;
                REG_HDR_PULSE:  hdr_pulse_reg  <= cfg_data;
                REG_HDR_SPACE:  hdr_space_reg  <= cfg_data;
                REG_ONE_PULSE:  one_pulse_reg  <= cfg_data;
                REG_ZERO_PULSE: zero_pulse_reg <= cfg_data;
                REG_GAP:        gap_reg        <= cfg_data;
                REG_TRAILER:    trailer_reg    <= cfg_data;
                default:        variants_reg   <= variants_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INACTIVE;
            shift_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            variant_reg <= variant_next;
            code_reg    <= code_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, code_reg, variant_reg};

endmodule

// File: hw/rtl/sirc_checker.sv
module sirc_checker
    import sirc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // each accepted word yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted word");

    // a waiting result blocks new input
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    a_zero_unless_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_KEY) |-> m_tdata == 32'd0)
        else $error("payload set without decoded key");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3) && (m_tdata[1:0] != 2'd3))
        else $error("bad status or variant code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind sirc_ir_pulse_decoder_core sirc_checker u_sirc_checker (.*);
